@@ rtl/mmt_pkg.sv @@
// Shared types and constants of the multiset mex tracker.
package mmt_pkg;

   localparam int VALUE_W = 12;
   localparam int COUNT_W = 16;
   localparam int MEX_W   = 13;

   typedef logic [VALUE_W-1:0] value_type;
   typedef logic [COUNT_W-1:0] count_type;
   typedef logic [MEX_W-1:0]   mex_type;

   localparam count_type COUNT_MAX = {COUNT_W{1'b1}};

   // Operation codes of a request
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

endpackage

@@ rtl/mmt_ram.sv @@
// Single-port-write, single-port-read synchronous memory with registered read data.
module mmt_ram #(
   parameter int WIDTH  = 16,
   parameter int DEPTH  = 4096,
   parameter int ADDR_W = 12
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // Read port, registered read data
   always_ff @(posedge clock) begin
      rdata <= mem[raddr];
   end

endmodule

@@ rtl/mmt_zero_find.sv @@
// Priority encoder that locates the lowest clear bit of a vector.
module mmt_zero_find #(
   parameter int WIDTH = 64,
   parameter int IDX_W = 6
) (
   input  logic [WIDTH-1:0] vec,
   output logic             found,
   output logic [IDX_W-1:0] idx
);

   // Scan from the top so the lowest clear bit wins
   always_comb begin
      found = ~&vec;
      idx   = '0;
      for (int i = WIDTH - 1; i >= 0; i--) begin
         if (!vec[i]) begin
            idx = IDX_W'(i);
         end
      end
   end

endmodule

@@ rtl/multiset_mex_tracker_core.sv @@
// Top level of the multiset mex tracker: control sequencer, count and presence stores.
//
//   channel   ports                                   handshake
//   request   start, busy, req_type, req_item_value   taken when start & !busy
//   response  rsp_strobe, rsp_smallest_absent         one cycle per result, no stall
//
// Each transaction runs these steps from acceptance to result: read of the count
// and presence row, read-modify-write, block search over the full flags, and the
// scan of the selected presence row. busy stays high until the result is shown.
// After reset a clearing pass over every address zeroes both memories; busy is
// high meanwhile. The receiver cannot stall; a result is shown for one cycle only.
module multiset_mex_tracker_core
   import mmt_pkg::*;
#(
   parameter int NUM_VALUES = 4096,
   parameter int BLOCK_SIZE = 64
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      start,
   output logic      busy,
   input  logic      req_type,
   input  value_type req_item_value,
   output logic      rsp_strobe,
   output mex_type   rsp_smallest_absent
);

   localparam int NUM_BLOCKS = (NUM_VALUES + BLOCK_SIZE - 1) / BLOCK_SIZE;
   localparam int VAL_W      = $clog2(NUM_VALUES);
   localparam int BS_W       = $clog2(BLOCK_SIZE);
   localparam int NB_W       = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int EXT_W      = (VAL_W > VALUE_W) ? VAL_W : VALUE_W;
   localparam int CALC_W     = (VAL_W + 1 > MEX_W) ? VAL_W + 1 : MEX_W;
   localparam int LAST_LEN   = NUM_VALUES - (NUM_BLOCKS - 1) * BLOCK_SIZE;

   // Block index by reciprocal multiplication, exact for every request value
   localparam int SHIFT      = VALUE_W + BS_W;
   localparam int RECIP      = ((1 << SHIFT) + BLOCK_SIZE - 1) / BLOCK_SIZE;
   localparam int RECIP_W    = $clog2(RECIP + 1);
   localparam int PROD_W     = VALUE_W + RECIP_W;

   localparam logic [BLOCK_SIZE-1:0] LAST_MASK =
      {BLOCK_SIZE{1'b1}} >> (BLOCK_SIZE - LAST_LEN);

   // Sequencer states
   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_UPDATE = 3'd2;
   localparam logic [2:0] ST_FIND   = 3'd3;
   localparam logic [2:0] ST_SCAN   = 3'd4;

   logic [2:0]            state_ff, state_in;
   logic [VAL_W-1:0]      clr_cnt_ff, clr_cnt_in;
   logic                  op_ff, op_in;
   logic                  in_range_ff, in_range_in;
   logic [VAL_W-1:0]      addr_ff, addr_in;
   logic [NB_W-1:0]       blk_ff, blk_in;
   logic [NB_W-1:0]       scan_blk_ff, scan_blk_in;
   logic                  open_ff, open_in;
   logic [NUM_BLOCKS-1:0] full_ff, full_in;
   logic                  rsp_strobe_ff, rsp_strobe_in;
   mex_type               rsp_mex_ff, rsp_mex_in;

   logic                  accept;
   logic [EXT_W-1:0]      val_ext;
   logic [PROD_W-1:0]     prod;
   logic [PROD_W-1:0]     blk_wide;

   logic                  occ_we;
   logic [VAL_W-1:0]      occ_waddr;
   count_type             occ_wdata;
   logic [VAL_W-1:0]      occ_raddr;
   count_type             occ_rdata;

   logic                  bm_we;
   logic [NB_W-1:0]       bm_waddr;
   logic [BLOCK_SIZE-1:0] bm_wdata;
   logic [NB_W-1:0]       bm_raddr;
   logic [BLOCK_SIZE-1:0] bm_rdata;

   count_type             new_cnt;
   logic [VAL_W-1:0]      pos_wide;
   logic [BS_W-1:0]       row_pos;
   logic [BLOCK_SIZE-1:0] new_row;
   logic [BLOCK_SIZE-1:0] upd_mask;
   logic [BLOCK_SIZE-1:0] scan_mask;
   logic [BLOCK_SIZE-1:0] scan_row;

   logic                  blk_found;
   logic [NB_W-1:0]       blk_idx;
   logic                  pos_found;
   logic [BS_W-1:0]       pos_idx;
   logic [CALC_W-1:0]     mex_calc;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   // Split the request value into memory address and block index
   assign val_ext  = EXT_W'(req_item_value);
   assign prod     = PROD_W'(req_item_value) * PROD_W'(RECIP);
   assign blk_wide = prod >> SHIFT;

   // Saturating count update and presence row update
   always_comb begin
      new_cnt = occ_rdata;
      if (op_ff == OP_INSERT) begin
         if (occ_rdata != COUNT_MAX) begin
            new_cnt = occ_rdata + count_type'(1);
         end
      end else begin
         if (occ_rdata != '0) begin
            new_cnt = occ_rdata - count_type'(1);
         end
      end
      pos_wide         = addr_ff - VAL_W'(blk_ff) * VAL_W'(BLOCK_SIZE);
      row_pos          = pos_wide[BS_W-1:0];
      new_row          = bm_rdata;
      new_row[row_pos] = (new_cnt != '0);
      upd_mask         = (32'(blk_ff) == NUM_BLOCKS - 1) ? LAST_MASK : '1;
   end

   // Memory port selection
   always_comb begin
      occ_we    = 1'b0;
      occ_waddr = addr_ff;
      occ_wdata = new_cnt;
      bm_we     = 1'b0;
      bm_waddr  = blk_ff;
      bm_wdata  = new_row;
      occ_raddr = val_ext[VAL_W-1:0];
      bm_raddr  = blk_wide[NB_W-1:0];
      priority case (state_ff)
         ST_CLEAR: begin
            occ_we    = 1'b1;
            occ_waddr = clr_cnt_ff;
            occ_wdata = '0;
            bm_we     = (32'(clr_cnt_ff) < NUM_BLOCKS);
            bm_waddr  = clr_cnt_ff[NB_W-1:0];
            bm_wdata  = '0;
         end
         ST_UPDATE: begin
            occ_we = in_range_ff;
            bm_we  = in_range_ff;
         end
         ST_FIND: begin
            bm_raddr = blk_idx;
         end
         default: begin
         end
      endcase
   end

   // First block that is not full
   mmt_zero_find #(
      .WIDTH (NUM_BLOCKS),
      .IDX_W (NB_W)
   ) u_blk_find (
      .vec   (full_ff),
      .found (blk_found),
      .idx   (blk_idx)
   );

   // First absent value inside the selected block
   assign scan_mask = (32'(scan_blk_ff) == NUM_BLOCKS - 1) ? LAST_MASK : '1;
   assign scan_row  = bm_rdata | ~scan_mask;

   mmt_zero_find #(
      .WIDTH (BLOCK_SIZE),
      .IDX_W (BS_W)
   ) u_pos_find (
      .vec   (scan_row),
      .found (pos_found),
      .idx   (pos_idx)
   );

   always_comb begin
      if (open_ff && pos_found) begin
         mex_calc = CALC_W'(scan_blk_ff) * CALC_W'(BLOCK_SIZE) + CALC_W'(pos_idx);
      end else begin
         mex_calc = CALC_W'(NUM_VALUES);
      end
   end

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      clr_cnt_in    = clr_cnt_ff;
      op_in         = op_ff;
      in_range_in   = in_range_ff;
      addr_in       = addr_ff;
      blk_in        = blk_ff;
      scan_blk_in   = scan_blk_ff;
      open_in       = open_ff;
      full_in       = full_ff;
      rsp_strobe_in = 1'b0;
      rsp_mex_in    = rsp_mex_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + VAL_W'(1);
            if (32'(clr_cnt_ff) == NUM_VALUES - 1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               op_in       = req_type;
               in_range_in = (32'(req_item_value) < NUM_VALUES);
               addr_in     = val_ext[VAL_W-1:0];
               blk_in      = blk_wide[NB_W-1:0];
               state_in    = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (in_range_ff) begin
               full_in[blk_ff] = &(new_row | ~upd_mask);
            end
            state_in = ST_FIND;
         end
         ST_FIND: begin
            scan_blk_in = blk_idx;
            open_in     = blk_found;
            state_in    = ST_SCAN;
         end
         ST_SCAN: begin
            rsp_strobe_in = 1'b1;
            rsp_mex_in    = mex_calc[MEX_W-1:0];
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // Hold control state; reset starts the clearing pass
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_cnt_ff    <= '0;
         full_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_cnt_ff    <= clr_cnt_in;
         full_ff       <= full_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      in_range_ff <= in_range_in;
      addr_ff     <= addr_in;
      blk_ff      <= blk_in;
      scan_blk_ff <= scan_blk_in;
      open_ff     <= open_in;
      rsp_mex_ff  <= rsp_mex_in;
   end

   // Occurrence counts, one entry per value
   mmt_ram #(
      .WIDTH  (COUNT_W),
      .DEPTH  (NUM_VALUES),
      .ADDR_W (VAL_W)
   ) u_occ_ram (
      .clock (clock),
      .we    (occ_we),
      .waddr (occ_waddr),
      .wdata (occ_wdata),
      .raddr (occ_raddr),
      .rdata (occ_rdata)
   );

   // Presence bitmap, one row per block
   mmt_ram #(
      .WIDTH  (BLOCK_SIZE),
      .DEPTH  (NUM_BLOCKS),
      .ADDR_W (NB_W)
   ) u_bm_ram (
      .clock (clock),
      .we    (bm_we),
      .waddr (bm_waddr),
      .wdata (bm_wdata),
      .raddr (bm_raddr),
      .rdata (bm_rdata)
   );

   assign rsp_strobe          = rsp_strobe_ff;
   assign rsp_smallest_absent = rsp_mex_ff;

endmodule

@@ rtl/mmt_checker.sv @@
// Port-level checks of the multiset mex tracker and their binding to the top level.
module mmt_checker
   import mmt_pkg::*;
#(
   parameter int NUM_VALUES = 4096
) (
   input logic      clock,
   input logic      reset,
   input logic      start,
   input logic      busy,
   input logic      rsp_strobe,
   input mex_type   rsp_smallest_absent
);

   // An accepted transaction makes the block busy
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after accepted transaction");

   // Each accepted transaction yields its result
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##4 rsp_strobe)
      else $error("result missing four cycles after transaction");

   // One result per transaction, never two in a row
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for more than one cycle");

   // A result appears only once the block is free again
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result shown while busy");

   // The mex never exceeds the number of values
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (32'(rsp_smallest_absent) <= NUM_VALUES))
      else $error("result beyond value range");

endmodule

bind multiset_mex_tracker_core mmt_checker #(
   .NUM_VALUES (NUM_VALUES)
) u_mmt_checker (
   .clock               (clock),
   .reset               (reset),
   .start               (start),
   .busy                (busy),
   .rsp_strobe          (rsp_strobe),
   .rsp_smallest_absent (rsp_smallest_absent)
);

@@ tb/sv/multiset_mex_tracker_core_tb.sv @@
// Self-checking testbench of the multiset mex tracker core: queued driver, monitor, mex predictor.
module multiset_mex_tracker_core_tb;
   import mmt_pkg::*;

   localparam int NUM_VALUES  = 4096;
   localparam int BLOCK_SIZE  = 64;
   localparam int NUM_BLOCKS  = (NUM_VALUES + BLOCK_SIZE - 1) / BLOCK_SIZE;
   localparam int CYCLE_LIMIT = 2_000_000;
   localparam int FILL_ITEMS  = 2 * BLOCK_SIZE;
   localparam int RAND_ITEMS  = 1100;

   // One pending update, with the sender behavior that applies to it
   typedef struct {
      logic        op;
      value_type   value;
      int unsigned idle_pct;
      bit          drain;
   } update_item_type;

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      start = 1'b0;
   logic      busy;
   logic      req_type = OP_INSERT;
   value_type req_item_value = '0;
   logic      rsp_strobe;
   mex_type   rsp_smallest_absent;

   update_item_type pending_updates[$];
   mex_type         mex_expected[$];

   // Predicted multiset contents
   count_type   occ_count[NUM_VALUES];
   int unsigned blk_present[NUM_BLOCKS];

   int unsigned n_taken = 0;
   int unsigned n_strobes_seen = 0;
   int unsigned n_results = 0;
   int unsigned n_errors = 0;
   int unsigned n_saturated = 0;
   int unsigned n_absent_removes = 0;
   int unsigned n_all_present = 0;
   int unsigned n_total = 0;
   int unsigned cycle_count = 0;

   multiset_mex_tracker_core #(
      .NUM_VALUES(NUM_VALUES),
      .BLOCK_SIZE(BLOCK_SIZE)
   ) u_top (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_type           (req_type),
      .req_item_value     (req_item_value),
      .rsp_strobe         (rsp_strobe),
      .rsp_smallest_absent(rsp_smallest_absent)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Apply one update to the predicted multiset and return the new mex
   function automatic mex_type apply_and_find_mex(input logic op, input value_type val);
      int unsigned blk;
      int unsigned pos;
      count_type   c;
      blk = val / BLOCK_SIZE;
      c   = occ_count[val];
      if (op == OP_INSERT) begin
         if (c != COUNT_MAX) begin
            if (c == '0) blk_present[blk]++;
            occ_count[val] = c + 1'b1;
         end else begin
            n_saturated++;
         end
      end else begin
         if (c != '0) begin
            if (c == count_type'(1)) blk_present[blk]--;
            occ_count[val] = c - 1'b1;
         end else begin
            n_absent_removes++;
         end
      end
      // skip full blocks, then scan the first block with a hole
      blk = 0;
      while (blk < NUM_BLOCKS && blk_present[blk] == BLOCK_SIZE) blk++;
      if (blk == NUM_BLOCKS) return mex_type'(NUM_VALUES);
      pos = blk * BLOCK_SIZE;
      while (occ_count[pos] != '0) pos++;
      return mex_type'(pos);
   endfunction

   task automatic add_update(input logic op, input int unsigned val,
                             input int unsigned idle_pct, input bit drain);
      update_item_type it;
      it.op       = op;
      it.value    = value_type'(val);
      it.idle_pct = idle_pct;
      it.drain    = drain;
      pending_updates.insert(pending_updates.size(), it);
   endtask

   task automatic report_mismatch(input string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      n_errors++;
   endtask

   // Driver: launch queued transactions, predict each one on acceptance
   always @(posedge clock) begin : drive_proc
      update_item_type nxt;
      bit              take;
      bit              go;
      mex_type         pred;
      if (reset) begin
         start          <= 1'b0;
         req_type       <= OP_INSERT;
         req_item_value <= '0;
      end else begin
         take = start && !busy;
         if (rsp_strobe === 1'b1) n_strobes_seen++;
         if (take) begin
            pred = apply_and_find_mex(req_type, req_item_value);
            mex_expected.insert(mex_expected.size(), pred);
            void'(pending_updates.pop_front());
            n_taken++;
         end
         // hold a transaction that has not been taken yet
         if (!(start && !take)) begin
            go = 1'b0;
            if (pending_updates.size() != 0) begin
               nxt = pending_updates[0];
               go  = !(nxt.drain && n_taken != n_strobes_seen) &&
                     ($urandom_range(0, 99) >= nxt.idle_pct);
            end
            if (go) begin
               start          <= 1'b1;
               req_type       <= nxt.op;
               req_item_value <= nxt.value;
            end else begin
               // drive noise on the fields while idle
               start          <= 1'b0;
               req_type       <= 1'($urandom_range(0, 1));
               req_item_value <= value_type'($urandom_range(0, NUM_VALUES - 1));
            end
         end
      end
   end

   // Monitor: compare each result with the oldest prediction
   always @(posedge clock) begin : monitor_proc
      mex_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         n_results++;
         if (mex_expected.size() == 0) begin
            report_mismatch($sformatf("result %0d (mex %0d) with no transaction pending",
                                      n_results, rsp_smallest_absent));
         end else begin
            want = mex_expected.pop_front();
            if (want == mex_type'(NUM_VALUES)) n_all_present++;
            if (rsp_smallest_absent !== want)
               report_mismatch($sformatf("result %0d: smallest_absent %0d, expected %0d",
                                         n_results, rsp_smallest_absent, want));
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d of %0d transactions taken, %0d pending",
                  cycle_count, n_taken, n_total, mex_expected.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin : stimulus_proc
      int unsigned focus;
      int unsigned idle;
      int unsigned val;
      for (int i = 0; i < NUM_VALUES; i++) occ_count[i] = '0;
      for (int b = 0; b < NUM_BLOCKS; b++) blk_present[b] = 0;

      // directed: empty set, absent removes, duplicates, extremes of the value
      add_update(OP_INSERT, 0, 37, 1'b0);
      add_update(OP_REMOVE, 0, 37, 1'b0);
      add_update(OP_REMOVE, 0, 37, 1'b0);
      add_update(OP_INSERT, NUM_VALUES - 1, 37, 1'b0);
      add_update(OP_INSERT, 0, 37, 1'b0);
      add_update(OP_INSERT, 0, 37, 1'b0);
      add_update(OP_REMOVE, 0, 37, 1'b0);
      add_update(OP_INSERT, 2, 37, 1'b0);
      add_update(OP_INSERT, 1, 37, 1'b0);
      add_update(OP_INSERT, 3, 37, 1'b0);
      add_update(OP_REMOVE, NUM_VALUES - 1, 37, 1'b0);
      add_update(OP_REMOVE, NUM_VALUES - 1, 37, 1'b0);
      add_update(OP_INSERT, BLOCK_SIZE - 1, 37, 1'b0);
      add_update(OP_INSERT, BLOCK_SIZE, 37, 1'b0);
      add_update(OP_INSERT, 4, 37, 1'b0);
      add_update(OP_REMOVE, 1, 37, 1'b0);
      add_update(OP_INSERT, 1, 0, 1'b1);
      add_update(OP_REMOVE, BLOCK_SIZE - 1, 0, 1'b0);
      add_update(OP_REMOVE, BLOCK_SIZE, 0, 1'b0);

      // fill the first two blocks in scrambled order so the search must skip them
      for (int i = 0; i < FILL_ITEMS; i++)
         add_update(OP_INSERT, (i * 45 + 17) % FILL_ITEMS, 10, i == 0);
      add_update(OP_REMOVE, BLOCK_SIZE + 5, 10, 1'b0);
      add_update(OP_INSERT, BLOCK_SIZE + 5, 10, 1'b0);

      // random: clustered updates around a moving focus, some anywhere
      focus = 0;
      for (int i = 0; i < RAND_ITEMS; i++) begin
         if (i < RAND_ITEMS / 3) idle = 37;
         else if (i < 2 * RAND_ITEMS / 3) idle = 51;
         else idle = 0;
         if ($urandom_range(0, 19) == 0) focus = $urandom_range(0, NUM_VALUES - 1);
         if ($urandom_range(0, 9) < 7) val = (focus + $urandom_range(0, 15)) % NUM_VALUES;
         else val = $urandom_range(0, NUM_VALUES - 1);
         add_update(1'($urandom_range(0, 1)), val, idle, (i % 250) == 0);
      end
      n_total = pending_updates.size();

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // drain: all taken, all results back
      while (n_taken < n_total) @(posedge clock);
      while (mex_expected.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);

      $display("covered %0d transactions, %0d results, %0d with every value present",
               n_taken, n_results, n_all_present);
      $display("%0d inserts at the count limit, %0d removes of absent values",
               n_saturated, n_absent_removes);
      if (n_errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/mmt_pkg.sv
rtl/mmt_ram.sv
rtl/mmt_zero_find.sv
rtl/multiset_mex_tracker_core.sv
rtl/mmt_checker.sv
tb/sv/multiset_mex_tracker_core_tb.sv
